FILE: rtl/vt2d_pkg.sv
// ----------------------------------------------------------------------------
// vt2d_pkg
// Types, constants, rounding and saturation helpers of the 2d vertex transform.
// ----------------------------------------------------------------------------
package vt2d_pkg;

  localparam int COORD_W = 32;
  localparam int TRIG_W  = 18;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int MODE_W  = 4;
  localparam int FRAC_W  = 16;

  localparam int OPA_W   = 33;
  localparam int PRD_W   = 65;
  localparam int OPB_W   = 36;
  localparam int PRD2_W  = 68;
  localparam int SUM_W   = 70;
  localparam int RND_W   = 54;

  localparam logic signed [SUM_W-1:0] HALF_LSB = 70'sd32768;
  localparam logic signed [RND_W-1:0] SAT_HI   = 54'sd2147483647;
  localparam logic signed [RND_W-1:0] SAT_LO   = -54'sd2147483648;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRANSLATE = 4'd0,
    MODE_ROTATE    = 4'd1,
    MODE_SCALE     = 4'd2,
    MODE_REFL_X    = 4'd3,
    MODE_REFL_Y    = 4'd4,
    MODE_REFL_YX   = 4'd5,
    MODE_REFL_YNX  = 4'd6,
    MODE_ORIGIN    = 4'd7,
    MODE_LINE      = 4'd8,
    MODE_SHEAR     = 4'd9
  } mode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE      = 3'd0,
    REG_PARAM_A   = 3'd1,
    REG_PARAM_B   = 3'd2,
    REG_PIVOT_X   = 3'd3,
    REG_PIVOT_Y   = 3'd4,
    REG_COS_VAL   = 3'd5,
    REG_SIN_VAL   = 3'd6,
    REG_INTERCEPT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    mode_e                     mode;
    logic signed [COORD_W-1:0] param_a;
    logic signed [COORD_W-1:0] param_b;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
    logic signed [TRIG_W-1:0]  cos_val;
    logic signed [TRIG_W-1:0]  sin_val;
    logic signed [COORD_W-1:0] intercept;
  } cfg_t;

  // round to nearest, ties toward plus infinity
  function automatic logic signed [RND_W-1:0] rnd16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = v + HALF_LSB;
    return $signed(t[SUM_W-1:FRAC_W]);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [RND_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/vt2d_if.sv
// ----------------------------------------------------------------------------
// vt2d_if
// Valid/ready stream interfaces for vertices in and transformed vertices out.
// ----------------------------------------------------------------------------
interface vt2d_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vt2d_pkg::COORD_W-1:0] vx;
  logic signed [vt2d_pkg::COORD_W-1:0] vy;
  logic                                last_vertex;

  modport source (output valid, output vx, output vy, output last_vertex, input ready);
  modport sink   (input valid, input vx, input vy, input last_vertex, output ready);
endinterface

interface vt2d_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vt2d_pkg::COORD_W-1:0] tx;
  logic signed [vt2d_pkg::COORD_W-1:0] ty;
  logic                                last_out;

  modport source (output valid, output tx, output ty, output last_out, input ready);
  modport sink   (input valid, input tx, input ty, input last_out, output ready);
endinterface

FILE: rtl/vertex_transform_2d.sv
// five register stages; an accepted vertex passes through all of them to the output
// throughput: one vertex per cycle unless the output stalls; two multiplier ranks
// the second rank depends on the rounded first rank (line reflection, shear)
// a stalled output holds its result; empty stages ahead of it keep filling
// reset clears all valid bits and loads the register defaults (cos 1.0, others 0)
// ----------------------------------------------------------------------------
// vertex_transform_2d
// Pipelined 2d affine transform of a Q16.16 vertex stream with saturation.
// ----------------------------------------------------------------------------
module vertex_transform_2d (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  vt2d_in_if.sink                           in_if,
  vt2d_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [vt2d_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [vt2d_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int CW = vt2d_pkg::COORD_W;
  localparam int AW = vt2d_pkg::OPA_W;
  localparam int PW = vt2d_pkg::PRD_W;
  localparam int BW = vt2d_pkg::OPB_W;
  localparam int QW = vt2d_pkg::PRD2_W;
  localparam int SW = vt2d_pkg::SUM_W;
  localparam int RW = vt2d_pkg::RND_W;

  vt2d_pkg::cfg_t cfg;

  vt2d_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // stage enables, bubbles collapse
  logic en1, en2, en3, en4, en_o;
  logic v1_q, v2_q, v3_q, v4_q, vo_q;

  assign en_o = !vo_q || out_if.ready;
  assign en4  = !v4_q || en_o;
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign in_if.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)  v1_q <= in_if.valid;
      if (en2)  v2_q <= v1_q;
      if (en3)  v3_q <= v2_q;
      if (en4)  v4_q <= v3_q;
      if (en_o) vo_q <= v4_q;
    end
  end

  // stage 1: offsets
  logic signed [CW-1:0] x1_q, y1_q;
  logic signed [AW-1:0] dx1_q, dy1_q, yl1_q;
  logic                 l1_q;
  logic signed [AW-1:0] dx1_d, dy1_d, yl1_d;

  assign dx1_d = AW'(in_if.vx) - AW'(cfg.pivot_x);
  assign dy1_d = AW'(in_if.vy) - AW'(cfg.pivot_y);
  assign yl1_d = AW'(in_if.vy) - AW'(cfg.intercept);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q  <= in_if.vx;
      y1_q  <= in_if.vy;
      l1_q  <= in_if.last_vertex;
      dx1_q <= dx1_d;
      dy1_q <= dy1_d;
      yl1_q <= yl1_d;
    end
  end

  // stage 2: first multiplier rank
  logic signed [AW-1:0] ua0, ua1, ua2, ua3;
  logic signed [CW-1:0] wa0, wa1, wa2, wa3;
  logic signed [CW-1:0] cos_e, sin_e;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [CW-1:0] x2_q, y2_q;
  logic                 l2_q;

  assign cos_e = CW'(cfg.cos_val);
  assign sin_e = CW'(cfg.sin_val);

  always_comb begin
    ua0 = '0; ua1 = '0; ua2 = '0; ua3 = '0;
    wa0 = '0; wa1 = '0; wa2 = '0; wa3 = '0;
    unique case (cfg.mode)
      vt2d_pkg::MODE_ROTATE: begin
        ua0 = dx1_q; wa0 = cos_e;
        ua1 = dy1_q; wa1 = sin_e;
        ua2 = dx1_q; wa2 = sin_e;
        ua3 = dy1_q; wa3 = cos_e;
      end
      vt2d_pkg::MODE_LINE: begin
        ua0 = AW'(x1_q); wa0 = cos_e;
        ua1 = yl1_q;     wa1 = sin_e;
        ua2 = AW'(x1_q); wa2 = sin_e;
        ua3 = yl1_q;     wa3 = cos_e;
      end
      vt2d_pkg::MODE_SCALE: begin
        ua0 = AW'(x1_q); wa0 = cfg.param_a;
        ua3 = AW'(y1_q); wa3 = cfg.param_b;
      end
      vt2d_pkg::MODE_SHEAR: begin
        ua0 = AW'(y1_q); wa0 = cfg.param_a;
      end
      default: begin
        ua0 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      p0_q <= ua0 * wa0;
      p1_q <= ua1 * wa1;
      p2_q <= ua2 * wa2;
      p3_q <= ua3 * wa3;
      x2_q <= x1_q;
      y2_q <= y1_q;
      l2_q <= l1_q;
    end
  end

  // stage 3: sum and round
  logic signed [RW-1:0] r0_d, r1_d, r0_q, r1_q;
  logic signed [CW-1:0] x3_q, y3_q;
  logic                 l3_q;

  always_comb begin
    r0_d = '0;
    r1_d = '0;
    unique case (cfg.mode)
      vt2d_pkg::MODE_ROTATE: begin
        r0_d = vt2d_pkg::rnd16(SW'(p0_q) - SW'(p1_q));
        r1_d = vt2d_pkg::rnd16(SW'(p2_q) + SW'(p3_q));
      end
      vt2d_pkg::MODE_LINE: begin
        r0_d = vt2d_pkg::rnd16(SW'(p0_q) + SW'(p1_q));
        r1_d = vt2d_pkg::rnd16(SW'(p3_q) - SW'(p2_q));
      end
      vt2d_pkg::MODE_SCALE: begin
        r0_d = vt2d_pkg::rnd16(SW'(p0_q));
        r1_d = vt2d_pkg::rnd16(SW'(p3_q));
      end
      vt2d_pkg::MODE_SHEAR: begin
        r0_d = RW'(vt2d_pkg::sat32(RW'(x2_q) + vt2d_pkg::rnd16(SW'(p0_q))));
      end
      default: begin
        r0_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      r0_q <= r0_d;
      r1_q <= r1_d;
      x3_q <= x2_q;
      y3_q <= y2_q;
      l3_q <= l2_q;
    end
  end

  // stage 4: second multiplier rank
  logic signed [BW-1:0] ub0, ub1;
  logic signed [CW-1:0] wb0, wb1, wb2, wb3;
  logic signed [QW-1:0] n0_q, n1_q, n2_q, n3_q;
  logic signed [RW-1:0] r0_4q, r1_4q;
  logic signed [CW-1:0] x4_q, y4_q;
  logic                 l4_q;

  assign ub0 = $signed(r0_q[BW-1:0]);
  assign ub1 = $signed(r1_q[BW-1:0]);

  always_comb begin
    wb0 = '0; wb1 = '0; wb2 = '0; wb3 = '0;
    unique case (cfg.mode)
      vt2d_pkg::MODE_LINE: begin
        wb0 = cos_e;
        wb1 = sin_e;
        wb2 = sin_e;
        wb3 = cos_e;
      end
      vt2d_pkg::MODE_SHEAR: begin
        wb0 = cfg.param_b;
      end
      default: begin
        wb0 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      n0_q  <= ub0 * wb0;
      n1_q  <= ub1 * wb1;
      n2_q  <= ub0 * wb2;
      n3_q  <= ub1 * wb3;
      r0_4q <= r0_q;
      r1_4q <= r1_q;
      x4_q  <= x3_q;
      y4_q  <= y3_q;
      l4_q  <= l3_q;
    end
  end

  // stage 5: final select and saturation
  logic signed [RW-1:0] xe, ye, fx, fy;
  logic signed [CW-1:0] tx_q, ty_q;
  logic                 lo_q;

  assign xe = RW'(x4_q);
  assign ye = RW'(y4_q);

  always_comb begin
    fx = xe;
    fy = ye;
    unique case (cfg.mode)
      vt2d_pkg::MODE_TRANSLATE: begin
        fx = xe + RW'(cfg.param_a);
        fy = ye + RW'(cfg.param_b);
      end
      vt2d_pkg::MODE_ROTATE: begin
        fx = r0_4q + RW'(cfg.pivot_x);
        fy = r1_4q + RW'(cfg.pivot_y);
      end
      vt2d_pkg::MODE_SCALE: begin
        fx = r0_4q;
        fy = r1_4q;
      end
      vt2d_pkg::MODE_REFL_X:   fy = -ye;
      vt2d_pkg::MODE_REFL_Y:   fx = -xe;
      vt2d_pkg::MODE_REFL_YX: begin
        fx = ye;
        fy = xe;
      end
      vt2d_pkg::MODE_REFL_YNX: begin
        fx = -ye;
        fy = -xe;
      end
      vt2d_pkg::MODE_ORIGIN: begin
        fx = -xe;
        fy = -ye;
      end
      vt2d_pkg::MODE_LINE: begin
        fx = vt2d_pkg::rnd16(SW'(n0_q) + SW'(n1_q));
        fy = vt2d_pkg::rnd16(SW'(n2_q) - SW'(n3_q)) + RW'(cfg.intercept);
      end
      vt2d_pkg::MODE_SHEAR: begin
        fx = r0_4q;
        fy = ye + vt2d_pkg::rnd16(SW'(n0_q));
      end
      default: begin
        fx = xe;
        fy = ye;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      tx_q <= vt2d_pkg::sat32(fx);
      ty_q <= vt2d_pkg::sat32(fy);
      lo_q <= l4_q;
    end
  end

  assign out_if.valid    = vo_q;
  assign out_if.tx       = tx_q;
  assign out_if.ty       = ty_q;
  assign out_if.last_out = lo_q;

endmodule

FILE: rtl/vt2d_regs.sv
// ----------------------------------------------------------------------------
// vt2d_regs
// Configuration register file of the 2d vertex transform.
// ----------------------------------------------------------------------------
module vt2d_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vt2d_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [vt2d_pkg::CFG_W-1:0]        cfg_data_i,
  output vt2d_pkg::cfg_t                    cfg_o
);

  vt2d_pkg::cfg_t   cfg_q;
  vt2d_pkg::cfg_t   cfg_d;
  vt2d_pkg::reg_idx_e idx;

  assign idx = vt2d_pkg::reg_idx_e'(cfg_idx_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (idx)
        vt2d_pkg::REG_MODE: begin
          cfg_d.mode = vt2d_pkg::mode_e'(cfg_data_i[vt2d_pkg::MODE_W-1:0]);
        end
        vt2d_pkg::REG_PARAM_A:   cfg_d.param_a   = $signed(cfg_data_i);
        vt2d_pkg::REG_PARAM_B:   cfg_d.param_b   = $signed(cfg_data_i);
        vt2d_pkg::REG_PIVOT_X:   cfg_d.pivot_x   = $signed(cfg_data_i);
        vt2d_pkg::REG_PIVOT_Y:   cfg_d.pivot_y   = $signed(cfg_data_i);
        vt2d_pkg::REG_COS_VAL: begin
          cfg_d.cos_val = $signed(cfg_data_i[vt2d_pkg::TRIG_W-1:0]);
        end
        vt2d_pkg::REG_SIN_VAL: begin
          cfg_d.sin_val = $signed(cfg_data_i[vt2d_pkg::TRIG_W-1:0]);
        end
        vt2d_pkg::REG_INTERCEPT: cfg_d.intercept = $signed(cfg_data_i);
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= vt2d_pkg::MODE_TRANSLATE;
      cfg_q.param_a   <= '0;
      cfg_q.param_b   <= '0;
      cfg_q.pivot_x   <= '0;
      cfg_q.pivot_y   <= '0;
      cfg_q.cos_val   <= 18'sd65536;
      cfg_q.sin_val   <= '0;
      cfg_q.intercept <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/vt2d_chk.sv
// ----------------------------------------------------------------------------
// vt2d_chk
// Port-level checks of the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
module vt2d_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [vt2d_pkg::COORD_W-1:0]      tx_i,
  input logic [vt2d_pkg::COORD_W-1:0]      ty_i,
  input logic                              last_i
);

  localparam logic [2:0] MAX_INFLIGHT = 3'd5;

  logic       in_acc, out_acc;
  logic [2:0] cnt_q, cnt_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 3'd1;
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(tx_i) && $stable(ty_i) && $stable(last_i))
    else $error("stalled result changed");

  // free-flowing pipeline delivers after five stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after pipeline latency");

  // no result without a pending transaction
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 3'd0)
    else $error("result without input transaction");

  // pipeline never holds more than its stage count
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_INFLIGHT)
    else $error("too many transactions in flight");

endmodule

bind vertex_transform_2d vt2d_chk u_vt2d_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .tx_i        (out_if.tx),
  .ty_i        (out_if.ty),
  .last_i      (out_if.last_out)
);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2d vertex transform. Vertices stream in through
// a bursty driver while the result side stalls on its own pattern; each
// accepted vertex is run through a Q16.16 predictor with a shadow copy of the
// registers, and every result transaction is compared against the oldest
// prediction. A short directed pass hits every mode and the rounding and
// saturation corners. Random phases with fresh register settings follow.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vt2d_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic                      last;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic                      last;
  } vertex_res_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_LIGHT, RX_HEAVY} rx_pace_e;

  localparam logic [COORD_W-1:0] W_MIN      = 32'h8000_0000;
  localparam logic [COORD_W-1:0] W_MAX      = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] ONE        = 32'h0001_0000;
  localparam logic [MODE_W-1:0]  MODE_SPARE = 4'd12;
  localparam longint             Q_MAX      = 64'sd2147483647;
  localparam longint             Q_MIN      = -64'sd2147483648;
  localparam int                 HOLD_PHASE = 3;
  localparam int                 HOLD_LEN   = 150;

  logic               clk_i;
  logic               rst_ni = 1'b1;
  logic               cfg_we_i;
  logic [IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;

  vt2d_in_if  in_vif ();
  vt2d_out_if out_vif ();

  vertex_transform_2d u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_vif),
    .out_if     (out_vif),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  cfg_t        shadow_cfg;
  vertex_t     vertex_q[$];
  vertex_res_t expect_q[$];
  vertex_t     next_vtx;
  vertex_res_t want;
  int          fail_cnt;
  int          phase_num;
  int          burst_left;
  int          gap_left;
  int          hold_left;
  logic        hold_done;
  rx_pace_e    rx_pace;
  int          pace_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_q16(input longint v);
    longint r;
    r = v;
    if (v > Q_MAX) begin
      r = Q_MAX;
    end else if (v < Q_MIN) begin
      r = Q_MIN;
    end
    return r[COORD_W-1:0];
  endfunction

  function automatic void turn(input longint x, input longint y, input longint c,
                               input longint s, output longint ox, output longint oy);
    ox = round_q16(x * c - y * s);
    oy = round_q16(x * s + y * c);
  endfunction

  function automatic vertex_res_t transform_vertex(input cfg_t c, input vertex_t v);
    vertex_res_t res;
    longint x, y, rx, ry, ax, ay, a, b, px, py, cs, sn, icpt;
    x    = $signed(v.vx);
    y    = $signed(v.vy);
    a    = $signed(c.param_a);
    b    = $signed(c.param_b);
    px   = $signed(c.pivot_x);
    py   = $signed(c.pivot_y);
    cs   = $signed(c.cos_val);
    sn   = $signed(c.sin_val);
    icpt = $signed(c.intercept);
    rx   = x;
    ry   = y;
    case (c.mode)
      MODE_TRANSLATE: begin
        rx = x + a;
        ry = y + b;
      end
      MODE_ROTATE: begin
        turn(x - px, y - py, cs, sn, ax, ay);
        rx = ax + px;
        ry = ay + py;
      end
      MODE_SCALE: begin
        rx = round_q16(x * a);
        ry = round_q16(y * b);
      end
      MODE_REFL_X:   ry = -y;
      MODE_REFL_Y:   rx = -x;
      MODE_REFL_YX: begin
        rx = y;
        ry = x;
      end
      MODE_REFL_YNX: begin
        rx = -y;
        ry = -x;
      end
      MODE_ORIGIN: begin
        rx = -x;
        ry = -y;
      end
      MODE_LINE: begin
        turn(x, y - icpt, cs, -sn, ax, ay);
        turn(ax, -ay, cs, sn, rx, ry);
        ry = ry + icpt;
      end
      MODE_SHEAR: begin
        rx = $signed(clamp_q16(x + round_q16(a * y)));
        ry = y + round_q16(b * rx);
      end
      default: begin
      end
    endcase
    res.tx   = clamp_q16(rx);
    res.ty   = clamp_q16(ry);
    res.last = v.last;
    return res;
  endfunction

  // vertex driver: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vif.valid       <= 1'b0;
      in_vif.vx          <= '0;
      in_vif.vy          <= '0;
      in_vif.last_vertex <= 1'b0;
      burst_left         <= 0;
      gap_left           <= 0;
    end else begin
      if (in_vif.valid && in_vif.ready) begin
        expect_q.push_back(transform_vertex(shadow_cfg,
                           '{in_vif.vx, in_vif.vy, in_vif.last_vertex}));
      end
      if (!in_vif.valid || in_vif.ready) begin
        if (gap_left != 0) begin
          in_vif.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (vertex_q.size() != 0) begin
          next_vtx           = vertex_q.pop_front();
          in_vif.valid       <= 1'b1;
          in_vif.vx          <= next_vtx.vx;
          in_vif.vy          <= next_vtx.vy;
          in_vif.last_vertex <= next_vtx.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_vif.valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vif.ready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
      rx_pace       <= RX_OPEN;
      pace_left     <= 0;
    end else if (phase_num == HOLD_PHASE && !hold_done) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_LEN;
      out_vif.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_vif.ready <= (hold_left == 1);
    end else begin
      if (pace_left == 0) begin
        rx_pace   <= rx_pace_e'($urandom_range(0, 3));
        pace_left <= $urandom_range(16, 96);
      end else begin
        pace_left <= pace_left - 1;
      end
      case (rx_pace)
        RX_OPEN:  out_vif.ready <= 1'b1;
        RX_COIN:  out_vif.ready <= ($urandom_range(0, 1) == 1);
        RX_LIGHT: out_vif.ready <= ($urandom_range(0, 3) != 0);
        default:  out_vif.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_vif.valid && out_vif.ready) begin
      if (expect_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("unexpected transaction: tx %0d ty %0d last %0b",
                   out_vif.tx, out_vif.ty, out_vif.last_out);
        end
      end else begin
        want = expect_q.pop_front();
        if (out_vif.tx !== want.tx || out_vif.ty !== want.ty
            || out_vif.last_out !== want.last) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch: tx exp %0d got %0d, ty exp %0d got %0d, last exp %0b got %0b",
                     want.tx, out_vif.tx, want.ty, out_vif.ty, want.last, out_vif.last_out);
          end
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic load_cfg(input logic [MODE_W-1:0] m, input logic [31:0] a,
                          input logic [31:0] b, input logic [31:0] px,
                          input logic [31:0] py, input logic [TRIG_W-1:0] c,
                          input logic [TRIG_W-1:0] s, input logic [31:0] icpt);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(REG_MODE, {junk[31:4], m});
    write_reg(REG_PARAM_A, a);
    write_reg(REG_PARAM_B, b);
    write_reg(REG_PIVOT_X, px);
    write_reg(REG_PIVOT_Y, py);
    write_reg(REG_COS_VAL, {junk[31:18], c});
    write_reg(REG_SIN_VAL, {junk[13:0], s});
    write_reg(REG_INTERCEPT, icpt);
    shadow_cfg.mode      = mode_e'(m);
    shadow_cfg.param_a   = a;
    shadow_cfg.param_b   = b;
    shadow_cfg.pivot_x   = px;
    shadow_cfg.pivot_y   = py;
    shadow_cfg.cos_val   = c;
    shadow_cfg.sin_val   = s;
    shadow_cfg.intercept = icpt;
    @(negedge clk_i);
  endtask

  task automatic add_vertex(input logic [31:0] x, input logic [31:0] y, input logic l);
    vertex_q.push_back('{x, y, l});
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (vertex_q.size() != 0 || in_vif.valid || expect_q.size() != 0);
  endtask

  function automatic logic [31:0] pick_param();
    case ($urandom_range(0, 7))
      0:       return W_MIN;
      1:       return W_MAX;
      2:       return '0;
      3:       return ONE;
      4, 5:    return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TRIG_W-1:0] pick_trig();
    case ($urandom_range(0, 5))
      0:       return 18'h20000;
      1:       return 18'h1FFFF;
      2:       return 18'h10000;
      3:       return '0;
      4:       return 18'($urandom_range(0, 1 << 17)) - 18'(1 << 16);
      default: return 18'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0:       return W_MIN;
          1:       return W_MAX;
          2:       return '0;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'h0000_8000;
          default: return 32'hFFFF_8000;
        endcase
      end
      1, 2, 3, 4: return 32'($urandom_range(0, 1 << 27)) - 32'(1 << 26);
      default:    return $urandom();
    endcase
  endfunction

  initial begin
    int          sent;
    int          n;
    logic [3:0]  m;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    fail_cnt   = 0;
    phase_num  = 0;
    shadow_cfg = '{mode: MODE_TRANSLATE, param_a: '0, param_b: '0, pivot_x: '0,
                   pivot_y: '0, cos_val: 18'h10000, sin_val: '0, intercept: '0};
    #0 rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // register defaults after reset
    add_vertex(W_MIN, W_MAX, 1'b0);
    add_vertex(W_MAX, W_MIN, 1'b1);
    drain();

    load_cfg(MODE_TRANSLATE, W_MAX, W_MIN, '0, '0, 18'h10000, '0, '0);
    add_vertex(W_MAX, W_MIN, 1'b0);
    add_vertex(W_MIN, W_MAX, 1'b1);
    drain();

    // non-normalized trig extremes, pivot at the corners
    load_cfg(MODE_ROTATE, '0, '0, W_MAX, W_MIN, 18'h20000, 18'h1FFFF, '0);
    add_vertex(W_MIN, W_MAX, 1'b0);
    add_vertex('0, '0, 1'b1);
    drain();

    // half scale gives rounding ties on odd lsbs
    load_cfg(MODE_SCALE, 32'h0000_8000, W_MIN, '0, '0, 18'h10000, '0, '0);
    add_vertex(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    add_vertex(32'hFFFF_FFFF, W_MIN, 1'b1);
    drain();

    load_cfg(MODE_REFL_X, W_MIN, W_MAX, '0, '0, 18'h10000, '0, '0);
    add_vertex('0, W_MIN, 1'b0);
    add_vertex(32'd5, 32'd7, 1'b1);
    drain();

    load_cfg(MODE_REFL_Y, '0, '0, W_MIN, W_MAX, 18'h10000, '0, '0);
    add_vertex(W_MIN, 32'd3, 1'b1);
    add_vertex(W_MAX, 32'hFFFF_FFFC, 1'b0);
    drain();

    load_cfg(MODE_REFL_YX, '0, '0, '0, '0, 18'h10000, '0, '0);
    add_vertex(W_MIN, W_MAX, 1'b0);
    add_vertex(32'd1, 32'd2, 1'b1);
    drain();

    load_cfg(MODE_REFL_YNX, '0, '0, '0, '0, 18'h10000, '0, '0);
    add_vertex(W_MIN, W_MAX, 1'b0);
    add_vertex(32'd3, 32'hFFFF_FFFE, 1'b1);
    drain();

    load_cfg(MODE_ORIGIN, '0, '0, '0, '0, 18'h10000, '0, '0);
    add_vertex(W_MIN, W_MIN, 1'b0);
    add_vertex(W_MAX, '0, 1'b1);
    drain();

    // 45 degree line through (0, 10)
    load_cfg(MODE_LINE, '0, '0, '0, '0, 18'h0B505, 18'h0B505, 32'h000A_0000);
    add_vertex(32'h0003_0000, ONE, 1'b0);
    add_vertex(W_MIN, W_MAX, 1'b1);
    drain();

    // x shear saturates, y shear works from the clamped x
    load_cfg(MODE_SHEAR, W_MAX, 32'hFFFF_8000, '0, '0, 18'h10000, '0, '0);
    add_vertex(W_MAX, 32'h0002_0000, 1'b0);
    add_vertex(32'hFFFF_0000, 32'hFFFF_0000, 1'b1);
    drain();

    load_cfg(MODE_SPARE, W_MAX, W_MAX, W_MIN, W_MIN, 18'h1FFFF, 18'h20000, W_MAX);
    add_vertex(W_MIN, W_MAX, 1'b0);
    add_vertex(32'd7, 32'hFFFF_FFF9, 1'b1);
    drain();

    for (int p = 0; p < 14; p++) begin
      m = (p < 10) ? p[3:0] : 4'($urandom_range(0, 15));
      load_cfg(m, pick_param(), pick_param(), pick_param(), pick_param(),
               pick_trig(), pick_trig(), pick_param());
      phase_num = p + 1;
      sent = 0;
      while (sent < 28) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        for (int k = 0; k < n; k++) begin
          add_vertex(pick_coord(), pick_coord(),
                     (k == n - 1) ? ($urandom_range(0, 9) != 0)
                                  : ($urandom_range(0, 19) == 0));
        end
        sent += n;
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
